// ===== design/rtfds_pkg.sv =====
// Shared types, widths and operation/status codes for the record table.
`default_nettype none

package rtfds_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_W = 31;
  localparam int ROLE_W = 2;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_MODIFY = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_ROLE  = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  localparam logic [ROLE_W-1:0] ROLE_NONE = '0;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ROLE_W-1:0] role;
  } rec_t;

  typedef struct packed {
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/rtfds_cell.sv =====
// One storage cell of the record ring: holds a record, loads its neighbor's.
`default_nettype none

module rtfds_cell import rtfds_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire rec_t      din,
  output rec_t           dout
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ===== design/record_table_find_delete_sort_top.sv =====
// Top level of the record table: a ring of cells walked by a small sequencer.
//
// Input channel (in_valid/in_ready) takes one operation per beat; output
// channel (out_valid/out_ready) returns exactly one result beat per operation.
// Records live in a ring of CAPACITY cells. Append, delete, modify, find and
// read rotate the ring once around, so the head cell sees each position in
// order and the ring is back in place at the end; clear and the unused code
// go straight to the result. Sort runs one scan rotation and one swap
// rotation per selection pass, over count - 1 passes, and goes straight to
// the result for fewer than two records.
// One operation is in flight at a time; in_ready is high only while the
// sequencer is idle. A result sits in the output register until taken; a
// stalled receiver holds the sequencer in its final state, and the next
// operation is accepted once that result has moved into the output register.
// Reset empties the table (the count goes to zero) and drops any pending
// result; cell contents are not cleared.
`default_nettype none

module record_table_find_delete_sort_top import rtfds_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        op,
  input  wire logic [ID_W-1:0]   key_id,
  input  wire logic [ID_W-1:0]   new_id,
  input  wire logic [ROLE_W-1:0] role,
  input  wire logic              descending,
  input  wire logic [5:0]        read_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             status,
  output logic [5:0]             found_index,
  output logic [ID_W-1:0]        entry_id,
  output logic [ROLE_W-1:0]      entry_role,
  output logic [6:0]             entry_count
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [SW-1:0] LAST = SW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWAP, S_DONE} state_t;

  state_t            state;
  logic [SW-1:0]     step;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              partial;
  logic              found;
  logic [SW-1:0]     fidx;
  rec_t              ent;
  rec_t              best;
  rec_t              save;
  logic [SW-1:0]     pick;
  logic [SW-1:0]     pa;
  logic [2:0]        op_q;
  logic [ID_W-1:0]   key_q;
  logic [ID_W-1:0]   nid_q;
  logic [ROLE_W-1:0] role_q;
  logic              desc_q;
  logic [5:0]        ridx_q;

  rec_t      cell_q [CAPACITY];
  rec_t      head;
  rec_t      tail_in;
  logic      shift;
  logic      in_rng;
  logic      hit;
  logic      better;
  logic      ridx_ok;
  logic [2:0]        res_status;
  logic [5:0]        res_fidx;
  rec_t              res_ent;

  assign head = cell_q[0];
  assign shift = (state == S_SCAN) || (state == S_SWAP);
  assign in_ready = (state == S_IDLE);
  assign in_rng = 32'(step) < 32'(count);
  assign ridx_ok = 32'(ridx_q) < 32'(count);
  assign better = desc_q ? (best.id < head.id) : (best.id > head.id);

  // Ring: each cell takes its upper neighbor; the tail takes the (possibly
  // replaced) head. After a delete match the top cell holds the dropped
  // record and the remaining cells rotate among themselves.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    rec_t      din;
    if (i == CAPACITY - 1) begin : g_tail
      assign din = tail_in;
      assign ctl.load = shift && !partial;
    end else if (i == CAPACITY - 2) begin : g_next
      assign din = partial ? cell_q[0] : cell_q[i+1];
      assign ctl.load = shift;
    end else begin : g_mid
      assign din = cell_q[i+1];
      assign ctl.load = shift;
    end
    rtfds_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .din  (din),
      .dout (cell_q[i])
    );
  end

  always_comb begin
    tail_in = head;
    hit = (state == S_SCAN) && in_rng && (head.id == key_q) && !found &&
          ((op_q == OP_DELETE) || (op_q == OP_MODIFY) || (op_q == OP_FIND));
    if (state == S_SCAN) begin
      if ((op_q == OP_APPEND) && (32'(step) == 32'(count)) && (role_q != ROLE_NONE)) begin
        tail_in = '{id: key_q, role: role_q};
      end
      if ((op_q == OP_MODIFY) && hit && (role_q != ROLE_NONE)) begin
        tail_in = '{id: nid_q, role: role_q};
      end
    end else if (state == S_SWAP) begin
      if (step == pa) begin
        tail_in = best;
      end else if (step == pick) begin
        tail_in = save;
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_fidx = '0;
    res_ent = '0;
    count_next = count;
    case (op_q)
      OP_APPEND: begin
        if (count >= FULL_COUNT) begin
          res_status = ST_FULL;
        end else if (role_q == ROLE_NONE) begin
          res_status = ST_BAD_ROLE;
        end else begin
          res_fidx = 6'(count);
          res_ent = '{id: key_q, role: role_q};
          count_next = count + 1'b1;
        end
      end
      OP_DELETE, OP_MODIFY, OP_FIND: begin
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_fidx = 6'(fidx);
          res_ent = ent;
          if ((op_q == OP_MODIFY) && (role_q == ROLE_NONE)) begin
            res_status = ST_BAD_ROLE;
          end
          if (op_q == OP_DELETE) begin
            count_next = count - 1'b1;
          end
        end
      end
      OP_READ: begin
        if (!ridx_ok) begin
          res_status = ST_RANGE;
        end else begin
          res_ent = ent;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      partial <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The final state reloads the output register itself.
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q <= op;
            key_q <= key_id;
            nid_q <= new_id;
            role_q <= role;
            desc_q <= descending;
            ridx_q <= read_index;
            step <= '0;
            found <= 1'b0;
            partial <= 1'b0;
            pa <= '0;
            ent <= '0;
            case (op)
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              OP_SORT: begin
                state <= (32'(count) >= 2) ? S_SCAN : S_DONE;
              end
              OP_APPEND, OP_DELETE, OP_MODIFY, OP_FIND, OP_READ: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          step <= (step == LAST) ? '0 : step + 1'b1;
          if (hit) begin
            found <= 1'b1;
            fidx <= step;
            ent <= ((op_q == OP_MODIFY) && (role_q != ROLE_NONE)) ?
                   rec_t'{id: nid_q, role: role_q} : head;
            if (op_q == OP_DELETE) begin
              partial <= 1'b1;
            end
          end
          if ((op_q == OP_READ) && (32'(step) == 32'(ridx_q))) begin
            ent <= head;
          end
          if (op_q == OP_SORT) begin
            if (step == pa) begin
              best <= head;
              pick <= step;
            end else if ((step > pa) && in_rng && better) begin
              best <= head;
              pick <= step;
            end
          end
          if (step == LAST) begin
            state <= (op_q == OP_SORT) ? S_SWAP : S_DONE;
          end
        end
        S_SWAP: begin
          step <= (step == LAST) ? '0 : step + 1'b1;
          if (step == pa) begin
            save <= head;
          end
          if (step == LAST) begin
            if (32'(pa) + 2 >= 32'(count)) begin
              state <= S_DONE;
            end else begin
              pa <= pa + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            found_index <= res_fidx;
            entry_id <= res_ent.id;
            entry_role <= res_ent.role;
            entry_count <= 7'(count_next);
            count <= count_next;
            partial <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rtfds_checker.sv =====
// Port-level checks for the record table, bound to the top level.
`default_nettype none

module rtfds_checker import rtfds_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        status,
  input wire logic [5:0]        found_index,
  input wire logic [ID_W-1:0]   entry_id,
  input wire logic [ROLE_W-1:0] entry_role,
  input wire logic [6:0]        entry_count
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Only one operation is in flight, so an accepted beat drops ready.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // A miss reports no record and no position.
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND) |->
      (found_index == '0) && (entry_id == '0) && (entry_role == ROLE_NONE))
    else $error("miss reported with record data");

  // The count never exceeds the table size.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(entry_count) <= CAPACITY)
    else $error("record count above capacity");

endmodule

bind record_table_find_delete_sort_top rtfds_checker #(.CAPACITY(CAPACITY)) u_rtfds_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .found_index (found_index),
  .entry_id    (entry_id),
  .entry_role  (entry_role),
  .entry_count (entry_count)
);

`default_nettype wire
